@@ sv/qbez_pkg.sv @@
// Shared types and constants for the quartic Bezier point evaluator.
`default_nettype none

package qbez_pkg;

  localparam int COORD_W  = 16;                     // signed Q12.4 coordinate
  localparam int T_FRAC   = 16;                     // fraction bits of t
  localparam int T_W      = T_FRAC + 1;             // t runs 0 .. 1.0 inclusive
  localparam int N_PTS    = 5;                      // control points
  localparam int N_LVL    = N_PTS - 1;              // interpolation levels
  localparam int PROD_W   = COORD_W + T_W + 2;      // diff * t, with sign margin
  localparam int PIPE_LAT = 1 + 2 * N_LVL;          // input stage + two per level
  localparam int TPIPE_N  = 2 * N_LVL - 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_W-1:0]            tparam_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam tparam_t T_ONE   = tparam_t'(1 << T_FRAC);
  localparam prod_t   ROUND_C = prod_t'(1 << (T_FRAC - 1));

  typedef struct packed {
    tparam_t t_param;
    coord_t  p0_x;
    coord_t  p0_y;
    coord_t  p1_x;
    coord_t  p1_y;
    coord_t  p2_x;
    coord_t  p2_y;
    coord_t  p3_x;
    coord_t  p3_y;
    coord_t  p4_x;
    coord_t  p4_y;
  } qbez_in_t;

  typedef struct packed {
    coord_t curve_x;
    coord_t curve_y;
  } qbez_out_t;

endpackage

`default_nettype wire

@@ sv/qbez_lerp.sv @@
// Two-stage rounded linear interpolation p + round((q - p) * t).
`default_nettype none

module qbez_lerp import qbez_pkg::*; (
  input  wire          clk,
  input  wire coord_t  p,
  input  wire coord_t  q,
  input  wire tparam_t t,
  output coord_t       r
);

  logic signed [COORD_W:0] diff;
  prod_t  prod_nxt;
  prod_t  prod_r;
  coord_t p_r;
  prod_t  rnd;
  prod_t  shifted;
  coord_t r_nxt;
  coord_t r_r;

  // stage A: difference and product
  assign diff     = $signed({q[COORD_W-1], q}) - $signed({p[COORD_W-1], p});
  assign prod_nxt = prod_t'(diff) * prod_t'($signed({1'b0, t}));

  // stage B: round to nearest (ties up), floor shift, add base point
  assign rnd     = prod_r + ROUND_C;
  assign shifted = rnd >>> T_FRAC;
  // true result lies between p and q, so a wrapping add is exact
  assign r_nxt   = coord_t'(p_r + coord_t'(shifted[COORD_W-1:0]));

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    p_r    <= p;
    r_r    <= r_nxt;
  end

  assign r = r_r;

endmodule

`default_nettype wire

@@ sv/quartic_bezier_point_eval.sv @@
// Top level: pipelined de Casteljau evaluation of a quartic Bezier curve.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   input    | start / busy           | in_data  (t, five x/y points)
//   result   | out_valid strobe       | out_data (curve_x, curve_y)
//
// One transfer in per cycle; each result passes through the registered stages:
// one input stage (t clamped to 1.0) then two stages per interpolation level
// (multiply, then round and add) for four levels. busy stays low: the pipeline
// never stalls and the receiver cannot hold results off. Synchronous reset
// clears the valid bits only; data stages run freely.
`default_nettype none

module quartic_bezier_point_eval import qbez_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  output logic          busy,
  input  wire qbez_in_t in_data,
  output logic          out_valid,
  output qbez_out_t     out_data
);

  logic [PIPE_LAT-1:0] vld_r;
  logic [PIPE_LAT-1:0] vld_nxt;
  tparam_t             t_sat;
  tparam_t             tpipe_r [0:TPIPE_N-1];
  coord_t              lx [0:N_LVL][0:N_PTS-1];
  coord_t              ly [0:N_LVL][0:N_PTS-1];
  coord_t              px_r [0:N_PTS-1];
  coord_t              py_r [0:N_PTS-1];
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign t_sat  = (in_data.t_param > T_ONE) ? T_ONE : in_data.t_param;

  assign vld_nxt = {vld_r[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // input stage; t follows its item, two stages per level
  always_ff @(posedge clk) begin
    tpipe_r[0] <= t_sat;
    for (int k = 1; k < TPIPE_N; k++) begin
      tpipe_r[k] <= tpipe_r[k-1];
    end
    px_r[0]    <= in_data.p0_x;
    py_r[0]    <= in_data.p0_y;
    px_r[1]    <= in_data.p1_x;
    py_r[1]    <= in_data.p1_y;
    px_r[2]    <= in_data.p2_x;
    py_r[2]    <= in_data.p2_y;
    px_r[3]    <= in_data.p3_x;
    py_r[3]    <= in_data.p3_y;
    px_r[4]    <= in_data.p4_x;
    py_r[4]    <= in_data.p4_y;
  end

  genvar gl, gi;
  generate
    for (gi = 0; gi < N_PTS; gi++) begin : g_lvl0
      assign lx[0][gi] = px_r[gi];
      assign ly[0][gi] = py_r[gi];
    end
    for (gl = 0; gl < N_LVL; gl++) begin : g_lvl
      for (gi = 0; gi < N_PTS; gi++) begin : g_pt
        if (gi < N_LVL - gl) begin : g_used
          qbez_lerp u_lerp_x (
            .clk (clk),
            .p   (lx[gl][gi]),
            .q   (lx[gl][gi+1]),
            .t   (tpipe_r[2*gl]),
            .r   (lx[gl+1][gi])
          );
          qbez_lerp u_lerp_y (
            .clk (clk),
            .p   (ly[gl][gi]),
            .q   (ly[gl][gi+1]),
            .t   (tpipe_r[2*gl]),
            .r   (ly[gl+1][gi])
          );
        end else begin : g_unused
          assign lx[gl+1][gi] = '0;
          assign ly[gl+1][gi] = '0;
        end
      end
    end
  endgenerate

  assign out_valid        = vld_r[PIPE_LAT-1];
  assign out_data.curve_x = lx[N_LVL][0];
  assign out_data.curve_y = ly[N_LVL][0];

  // every transfer yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("result strobe missing after transfer");

  // t of zero returns the first control point exactly
  a_t_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.t_param == '0) |-> ##PIPE_LAT
      (out_data.curve_x == $past(in_data.p0_x, PIPE_LAT) &&
       out_data.curve_y == $past(in_data.p0_y, PIPE_LAT)))
    else $error("t=0 did not return first control point");

  // t of one or above returns the last control point
  a_t_one: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.t_param >= T_ONE) |-> ##PIPE_LAT
      (out_data.curve_x == $past(in_data.p4_x, PIPE_LAT) &&
       out_data.curve_y == $past(in_data.p4_y, PIPE_LAT)))
    else $error("t>=1 did not return last control point");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the quartic Bezier point evaluator.
module testbench;
  import qbez_pkg::*;

  typedef enum {PTS_RANDOM, PTS_MAX, PTS_MIN, PTS_ALT, PTS_ZERO, PTS_MIXED} pts_mode_e;

  class bezier_scoreboard;
    qbez_out_t   pending_points[$];
    int unsigned n_transfers;
    int unsigned n_checked;
    int unsigned n_errors;

    // de Casteljau on one axis: four levels of rounded lerp
    function coord_t eval_axis(longint signed pts[N_PTS], longint signed t);
      longint signed w[N_PTS];
      longint signed half_t;
      half_t = longint'(1) << (T_FRAC - 1);
      w = pts;
      for (int lvl = N_LVL; lvl > 0; lvl--)
        for (int i = 0; i < lvl; i++)
          w[i] = w[i] + (((w[i+1] - w[i]) * t + half_t) >>> T_FRAC);
      return coord_t'(w[0]);
    endfunction

    function void note_transfer(qbez_in_t item);
      longint signed t;
      longint signed xs[N_PTS];
      longint signed ys[N_PTS];
      qbez_out_t     point;
      t = (item.t_param > T_ONE) ? T_ONE : item.t_param;
      xs[0] = item.p0_x; ys[0] = item.p0_y;
      xs[1] = item.p1_x; ys[1] = item.p1_y;
      xs[2] = item.p2_x; ys[2] = item.p2_y;
      xs[3] = item.p3_x; ys[3] = item.p3_y;
      xs[4] = item.p4_x; ys[4] = item.p4_y;
      point.curve_x = eval_axis(xs, t);
      point.curve_y = eval_axis(ys, t);
      pending_points.push_back(point);
      n_transfers++;
    endfunction

    function void check_point(qbez_out_t got);
      qbez_out_t want;
      if (pending_points.size() == 0) begin
        $error("result with no transfer pending: curve_x=%0d curve_y=%0d",
               got.curve_x, got.curve_y);
        n_errors++;
        return;
      end
      want = pending_points.pop_front();
      n_checked++;
      if (got.curve_x !== want.curve_x) begin
        $error("curve_x mismatch: expected %0d, got %0d", want.curve_x, got.curve_x);
        n_errors++;
      end
      if (got.curve_y !== want.curve_y) begin
        $error("curve_y mismatch: expected %0d, got %0d", want.curve_y, got.curve_y);
        n_errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  qbez_in_t  in_data;
  logic      out_valid;
  qbez_out_t out_data;

  bezier_scoreboard sb = new;

  quartic_bezier_point_eval u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_transfer(in_data);
      if (out_valid) sb.check_point(out_data);
    end
  end

  function automatic coord_t pick_coord(pts_mode_e mode, int idx);
    int r;
    case (mode)
      PTS_MAX:  return coord_t'(16'sh7FFF);
      PTS_MIN:  return coord_t'(16'sh8000);
      PTS_ZERO: return '0;
      // neighbors swing full scale in opposite directions
      PTS_ALT:  return (idx % 2 == 0) ? coord_t'(16'sh8000) : coord_t'(16'sh7FFF);
      PTS_MIXED: begin
        r = $urandom_range(0, 9);
        if (r == 0) return coord_t'(16'sh8000);
        if (r == 1) return coord_t'(16'sh7FFF);
        if (r == 2) return coord_t'($urandom_range(0, 63)) - coord_t'(32);
        return coord_t'($urandom);
      end
      default:  return coord_t'($urandom);
    endcase
  endfunction

  function automatic tparam_t pick_t();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return T_ONE;
    if (r <= 3) return tparam_t'($urandom_range(int'(T_ONE) + 1, (1 << T_W) - 1));
    return tparam_t'($urandom_range(0, int'(T_ONE)));
  endfunction

  function automatic qbez_in_t make_item(tparam_t t, pts_mode_e mode);
    coord_t   c[2*N_PTS];
    qbez_in_t item;
    // x of point k sits at 2k, y at 2k+1; y gets the opposite parity for PTS_ALT
    for (int k = 0; k < 2*N_PTS; k++)
      c[k] = pick_coord(mode, (k / 2) + (k % 2));
    item = '{t, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9]};
    return item;
  endfunction

  task automatic send_point(input qbez_in_t item, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  initial begin
    tparam_t   t_dir[7];
    int        idle_sched[3];
    int        drain;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    t_dir      = '{'0, tparam_t'(1), tparam_t'(32768), tparam_t'(65535), T_ONE,
                   T_ONE + tparam_t'(1), {T_W{1'b1}}};
    idle_sched = '{27, 79, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: t at zero, one, above one and in between, coordinate extremes
    foreach (t_dir[i]) begin
      send_point(make_item(t_dir[i], PTS_RANDOM), 27);
      send_point(make_item(t_dir[i], PTS_ALT), 27);
    end
    send_point(make_item(tparam_t'(32768), PTS_MAX), 27);
    send_point(make_item(tparam_t'(32768), PTS_MIN), 27);
    send_point(make_item(tparam_t'(32768), PTS_ZERO), 27);
    send_point(make_item(tparam_t'(16384), PTS_ALT), 27);

    foreach (idle_sched[ph])
      for (int n = 0; n < 667; n++)
        send_point(make_item(pick_t(), PTS_MIXED), idle_sched[ph]);
    start <= 1'b0;

    drain = 0;
    while (sb.pending_points.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);

    if (sb.pending_points.size() != 0) begin
      $error("%0d expected points never arrived", sb.pending_points.size());
      sb.n_errors++;
    end
    $display("run covered %0d transfers and %0d checked curve points, %0d mismatches",
             sb.n_transfers, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("timeout: run did not complete");
    $display("== FAIL ==");
    $finish;
  end

endmodule
